// File: rtl/opfs_pkg.sv
`timescale 1ns / 1ps

package opfs_pkg;

  localparam int CHAR_W = 7;
  localparam int WORD_W = CHAR_W + 1;
  localparam int BIT_CNT_W = $clog2(WORD_W);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W - 1);

  // Frame position codes.
  localparam logic [1:0] POS_HDR0 = 2'd0;
  localparam logic [1:0] POS_HDR1 = 2'd1;
  localparam logic [1:0] POS_HDR2 = 2'd2;
  localparam logic [1:0] POS_DATA = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              header;
    logic              last;
  } char_info_t;

endpackage

// File: rtl/opfs_char_enc.sv
`timescale 1ns / 1ps

module opfs_char_enc import opfs_pkg::*; (
  input  logic [CHAR_W-1:0] char_in,
  input  logic [1:0]        position,
  input  logic [CHAR_W-1:0] remaining,
  output char_info_t        info,
  output logic [1:0]        position_next,
  output logic [CHAR_W-1:0] remaining_next
);

  always_comb begin
    // Parity bit set when the character holds an even number of ones.
    info.word      = {~(^char_in), char_in};
    info.header    = 1'b0;
    info.last      = 1'b0;
    position_next  = position;
    remaining_next = remaining;
    case (position)
      POS_HDR0: begin
        info.header   = 1'b1;
        position_next = POS_HDR1;
      end
      POS_HDR1: begin
        info.header   = 1'b1;
        position_next = POS_HDR2;
      end
      POS_HDR2: begin
        info.header    = 1'b1;
        remaining_next = char_in;
        if (char_in == '0) begin
          info.last     = 1'b1;
          position_next = POS_HDR0;
        end else begin
          position_next = POS_DATA;
        end
      end
      default: begin
        if (remaining <= CHAR_W'(1)) begin
          info.last      = 1'b1;
          remaining_next = '0;
          position_next  = POS_HDR0;
        end else begin
          remaining_next = remaining - CHAR_W'(1);
        end
      end
    endcase
  end

endmodule

// File: rtl/odd_parity_frame_serializer.sv
`timescale 1ns / 1ps
// Path: an accepted character is registered in the input buffer, then loaded
// into the output shifter, from which its first line bit leaves.
// Throughput: one line bit per cycle while bit_stall is low, set by the output
// shift register; a one-character input buffer refills while it shifts.
// Reset (rst, synchronous, active high): empties both stages and returns the
// frame position to the first header byte with no data count.

module odd_parity_frame_serializer import opfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [CHAR_W-1:0] char7,
  output logic              bit_valid,
  input  logic              bit_stall,
  output logic              line_bit,
  output logic              in_header,
  output logic              char_end,
  output logic              frame_end
);

  // Input buffer: holds one character until the shifter can take it.
  logic              buf_full;
  logic [CHAR_W-1:0] buf_char;

  // Frame position and data count.
  logic [1:0]        position;
  logic [CHAR_W-1:0] remaining;
  logic [1:0]        position_next;
  logic [CHAR_W-1:0] remaining_next;

  // Output shifter: the current character's word, LSB on the line.
  logic                 sh_valid;
  logic [WORD_W-1:0]    sh_word;
  logic [BIT_CNT_W-1:0] sh_cnt;
  logic                 sh_header;
  logic                 sh_last;

  char_info_t info;
  logic       char_take;
  logic       bit_take;
  logic       sh_done;
  logic       load;

  opfs_char_enc u_enc (
    .char_in        (buf_char),
    .position       (position),
    .remaining      (remaining),
    .info           (info),
    .position_next  (position_next),
    .remaining_next (remaining_next)
  );

  // Stall comes straight from the buffer flag, so it never depends on valid.
  assign char_stall = buf_full;
  assign char_take  = char_valid && !buf_full;

  assign bit_take = sh_valid && !bit_stall;
  assign sh_done  = bit_take && (sh_cnt == LAST_BIT);
  // Move the buffered character into the shifter when it is empty or its
  // last beat leaves this cycle.
  assign load     = buf_full && (!sh_valid || sh_done);

  assign bit_valid = sh_valid;
  assign line_bit  = sh_word[0];
  assign in_header = sh_header;
  assign char_end  = (sh_cnt == LAST_BIT);
  assign frame_end = (sh_cnt == LAST_BIT) && sh_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full  <= 1'b0;
      sh_valid  <= 1'b0;
      sh_cnt    <= '0;
      position  <= POS_HDR0;
      remaining <= '0;
    end else begin
      if (char_take) begin
        buf_full <= 1'b1;
      end else if (load) begin
        buf_full <= 1'b0;
      end

      if (load) begin
        // Advance the frame state once per character, at load time.
        position  <= position_next;
        remaining <= remaining_next;
        sh_valid  <= 1'b1;
        sh_cnt    <= '0;
      end else if (sh_done) begin
        sh_valid <= 1'b0;
        sh_cnt   <= '0;
      end else if (bit_take) begin
        sh_cnt <= sh_cnt + BIT_CNT_W'(1);
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (char_take) begin
      buf_char <= char7;
    end
    if (load) begin
      sh_word   <= info.word;
      sh_header <= info.header;
      sh_last   <= info.last;
    end else if (bit_take) begin
      // Drop the bit just sent and shift the next one onto the line.
      sh_word <= {1'b0, sh_word[WORD_W-1:1]};
    end
  end

endmodule

// File: sim/tb_odd_parity_frame_serializer.sv
`timescale 1ns / 1ps

module tb_odd_parity_frame_serializer;
  import opfs_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int IDLE_PCT = 17;
  localparam int RANDOM_ITEMS = 280;
  // Cycles with no beat on either side before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Quiet cycles after the last line bit; the pipe is two stages deep.
  localparam int TAIL_CYCLES = 20;
  localparam logic [CHAR_W-1:0] CHAR_MAX = '1;

  // One expected line bit with its flags.
  typedef struct packed {
    logic line_bit;
    logic in_header;
    logic char_end;
    logic frame_end;
  } line_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              char_valid = 1'b0;
  logic [CHAR_W-1:0] char7 = '0;
  logic              bit_stall = 1'b0;
  logic              char_stall;
  logic              bit_valid;
  logic              line_bit;
  logic              in_header;
  logic              char_end;
  logic              frame_end;

  // Predictor state: where the next character falls in its frame.
  logic [1:0]        frame_pos = POS_HDR0;
  logic [CHAR_W-1:0] data_left = '0;

  line_beat_t pending_bits[$];
  int         mismatch_count = 0;
  int         chars_sent = 0;
  int         idle_cycles = 0;
  // Set to hold both sides busy with no random idling.
  bit         no_idle = 1'b0;

  odd_parity_frame_serializer u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char7      (char7),
    .bit_valid  (bit_valid),
    .bit_stall  (bit_stall),
    .line_bit   (line_bit),
    .in_header  (in_header),
    .char_end   (char_end),
    .frame_end  (frame_end)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("%0t: mismatch on %s: got %b, expected %b", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Work out the eight line bits that one accepted character produces and
  // queue them, advancing the frame position as the block should.
  task automatic queue_line_bits(input logic [CHAR_W-1:0] c);
    logic [WORD_W-1:0] word;
    logic              hdr;
    logic              last;
    line_beat_t        beat;
    int                i;
    // Odd parity: set bit 7 when the character holds an even number of ones.
    word = {~(^c), c};
    hdr = 1'b0;
    last = 1'b0;
    if (frame_pos != POS_DATA) begin
      hdr = 1'b1;
      if (frame_pos == POS_HDR2) begin
        // Third header byte carries the data length; zero closes the frame.
        data_left = c;
        if (c == '0) begin
          last = 1'b1;
          frame_pos = POS_HDR0;
        end else begin
          frame_pos = POS_DATA;
        end
      end else begin
        frame_pos = frame_pos + 2'd1;
      end
    end else if (data_left <= CHAR_W'(1)) begin
      last = 1'b1;
      data_left = '0;
      frame_pos = POS_HDR0;
    end else begin
      data_left = data_left - CHAR_W'(1);
    end
    for (i = 0; i < WORD_W; i++) begin
      beat.line_bit = word[i];
      beat.in_header = hdr;
      beat.char_end = (i == WORD_W - 1);
      beat.frame_end = (i == WORD_W - 1) && last;
      pending_bits.push_back(beat);
    end
  endtask

  // Send one character. Entered and left at a falling edge; valid stays high
  // on exit so a following beat goes out back to back.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    bit taken;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char7 <= c;
    do begin
      @(posedge clk);
      taken = !char_stall;
      if (taken) begin
        queue_line_bits(c);
        chars_sent++;
      end
      @(negedge clk);
    end while (!taken);
  endtask

  // Send a whole frame: two header bytes, the length byte, then random data.
  task automatic send_frame(input logic [CHAR_W-1:0] h0, input logic [CHAR_W-1:0] h1,
                            input logic [CHAR_W-1:0] len);
    int n;
    send_char(h0);
    send_char(h1);
    send_char(len);
    for (n = 0; n < len; n++) send_char(CHAR_W'($urandom_range(0, CHAR_MAX)));
  endtask

  // Drop valid and hold off until every queued line bit has come out.
  task automatic wait_drained();
    char_valid <= 1'b0;
    while (pending_bits.size() != 0) @(negedge clk);
  endtask

  // Header bytes at both extremes, and zero-length frames back to back.
  task automatic test_zero_length_frame();
    send_char('0);
    send_char(CHAR_MAX);
    send_char('0);
    send_char(CHAR_MAX);
    send_char('0);
    send_char('0);
  endtask

  // One- and two-character frames; data at both extremes and both parities.
  task automatic test_short_frames();
    send_char(7'h55);
    send_char(7'h2A);
    send_char(CHAR_W'(1));
    send_char(CHAR_MAX);
    send_char(7'h01);
    send_char(7'h03);
    send_char(CHAR_W'(2));
    send_char('0);
    send_char(7'h40);
  endtask

  // Maximum length byte, both sides streaming with no idling.
  task automatic test_longest_frame();
    no_idle = 1'b1;
    send_frame(CHAR_W'($urandom_range(0, CHAR_MAX)), CHAR_W'($urandom_range(0, CHAR_MAX)),
               CHAR_MAX);
    no_idle = 1'b0;
  endtask

  // Let the block run dry between frames, then resume back to back.
  task automatic test_pause_until_drained();
    send_frame(CHAR_W'($urandom_range(0, CHAR_MAX)), CHAR_W'($urandom_range(0, CHAR_MAX)),
               CHAR_W'(2));
    wait_drained();
    send_frame(CHAR_W'($urandom_range(0, CHAR_MAX)), CHAR_W'($urandom_range(0, CHAR_MAX)),
               CHAR_W'(1));
  endtask

  // Random frames, mostly short, now and then longer, with random content.
  task automatic test_random_frames();
    logic [CHAR_W-1:0] len;
    int                frames;
    frames = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) len = CHAR_W'($urandom_range(7, 40));
      else len = CHAR_W'($urandom_range(0, 6));
      send_frame(CHAR_W'($urandom_range(0, CHAR_MAX)), CHAR_W'($urandom_range(0, CHAR_MAX)),
                 len);
      frames++;
      // Drain now and then so the restart path is hit more than once.
      if (frames % 12 == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_zero_length_frame();
    test_short_frames();
    test_pause_until_drained();
    test_longest_frame();
    test_random_frames();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver side: stall at random, except during the no-idle stretch.
  always @(negedge clk) begin
    if (rst || no_idle) begin
      bit_stall <= 1'b0;
    end else begin
      bit_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Compare each accepted line bit with the oldest expectation.
  always @(posedge clk) begin
    line_beat_t want;
    if (!rst && bit_valid && !bit_stall) begin
      if (pending_bits.size() == 0) begin
        $display("%0t: line bit with nothing expected", $realtime);
        mismatch_count++;
      end else begin
        want = pending_bits.pop_front();
        if (line_bit !== want.line_bit) report_mismatch("line_bit", line_bit, want.line_bit);
        if (in_header !== want.in_header)
          report_mismatch("in_header", in_header, want.in_header);
        if (char_end !== want.char_end) report_mismatch("char_end", char_end, want.char_end);
        if (frame_end !== want.frame_end)
          report_mismatch("frame_end", frame_end, want.frame_end);
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (bit_valid && !bit_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no progress, %0d line bits outstanding", $realtime,
                 pending_bits.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

// File: files.f
rtl/opfs_pkg.sv
rtl/opfs_char_enc.sv
rtl/odd_parity_frame_serializer.sv
sim/tb_odd_parity_frame_serializer.sv
